// ===== rtl/ecrqd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ecrqd_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CODE_W      = 8;
    localparam int FUNC_W      = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ENQ      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENQ_ONCE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEQ      = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP      = 2'd3;

    // input request
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CODE_W-1:0] code_in;
    } req_t;

    // result
    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic              stored;
        logic              forwarded;
        logic              not_empty;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan_step;
        logic enq;
        logic deq;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_more;
        logic rd_pend;
        logic hit;
        logic out_free;
    } status_t;

    // pointer at or past the end addresses entry 0
    function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        logic [SLOT_W-1:0] s;
        s = (p < PTR_W'(QUEUE_DEPTH)) ? p[SLOT_W-1:0] : '0;
        return s;
    endfunction

    // advance a pointer, wrapping only in circular mode
    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                  input logic one_shot);
        logic [PTR_W-1:0] n;
        n = PTR_W'(slot_of(p)) + PTR_W'(1);
        if (!one_shot && n >= PTR_W'(QUEUE_DEPTH))
        begin
            n = '0;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/error_code_ring_queue_dedup_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// in        request    in_valid / in_stall   in_data   (func, code_in)
// out       result     out_valid / out_stall out_data  (code_out, stored, forwarded, not_empty)
// cfg       write      cfg_valid / cfg_ready cfg_data  (one_shot_mode)
//
// one request at a time: enqueue and dequeue go from accept through their own state to the
// response state, a no-op straight to it; enqueue-once first scans the live entries and
// enqueues when no copy is found, else responds at the first copy: one read port, one entry
// per cycle. reset clears both pointers and the mode; the code memory holds garbage until
// written. a held result does not block the next request, which finishes its work and
// waits in the response state for the result register.

module error_code_ring_queue_dedup_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire ecrqd_pkg::req_t in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output ecrqd_pkg::rsp_t      out_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic            cfg_data
);

    ecrqd_pkg::cmd_t    cmd;
    ecrqd_pkg::status_t sts;

    // sequencer
    ecrqd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // queue storage, pointers and result register
    ecrqd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ===== rtl/ecrqd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecrqd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire ecrqd_pkg::req_t   in_data,
    output logic                   in_stall,
    input  wire ecrqd_pkg::status_t sts,
    output ecrqd_pkg::cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_ENQ  = 5'b00100,
        S_DEQ  = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    unique case (in_data.func)
                        ecrqd_pkg::FUNC_ENQ:      state_next = S_ENQ;
                        ecrqd_pkg::FUNC_ENQ_ONCE: state_next = S_SCAN;
                        ecrqd_pkg::FUNC_DEQ:      state_next = S_DEQ;
                        default:                  state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN:
            begin
                // one entry read per cycle, compare on the next
                cmd.scan_step = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_RESP;
                end
                else if (!sts.scan_more && !sts.rd_pend)
                begin
                    state_next = S_ENQ;
                end
            end
            S_ENQ:
            begin
                cmd.enq    = 1'b1;
                state_next = S_RESP;
            end
            S_DEQ:
            begin
                cmd.deq    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ecrqd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecrqd_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ecrqd_pkg::req_t   in_data,
    input  wire ecrqd_pkg::cmd_t   cmd,
    output ecrqd_pkg::status_t     sts,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ecrqd_pkg::rsp_t        out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);

    logic [ecrqd_pkg::CODE_W-1:0] code_store_reg [ecrqd_pkg::QUEUE_DEPTH];
    logic [ecrqd_pkg::CODE_W-1:0] rd_data_reg;

    logic [ecrqd_pkg::PTR_W-1:0]  head_reg, head_next;
    logic [ecrqd_pkg::PTR_W-1:0]  tail_reg, tail_next;
    logic [ecrqd_pkg::PTR_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [ecrqd_pkg::PTR_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         mode_reg;
    logic                         out_valid_reg, out_valid_next;

    logic [ecrqd_pkg::CODE_W-1:0] code_reg;
    logic                         stored_reg, fwd_reg, deq_hit_reg;
    ecrqd_pkg::rsp_t              out_data_reg;

    logic                         rd_en;
    logic [ecrqd_pkg::SLOT_W-1:0] rd_addr;
    logic                         wr_en;
    logic                         frozen;
    logic                         q_not_empty;

    assign cfg_ready   = 1'b1;
    assign q_not_empty = (head_reg != tail_reg);
    assign frozen      = mode_reg && (head_reg >= ecrqd_pkg::PTR_W'(ecrqd_pkg::QUEUE_DEPTH));

    // status to controller
    assign sts.scan_more = (scan_ptr_reg != head_reg) &&
                           (scan_cnt_reg < ecrqd_pkg::PTR_W'(ecrqd_pkg::QUEUE_DEPTH));
    assign sts.rd_pend   = rd_pend_reg;
    assign sts.hit       = rd_pend_reg && (rd_data_reg == code_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // memory port selection
    assign wr_en   = cmd.enq && !frozen;
    assign rd_en   = (cmd.scan_step && sts.scan_more) || (cmd.deq && q_not_empty);
    assign rd_addr = cmd.deq ? ecrqd_pkg::slot_of(tail_reg)
                             : ecrqd_pkg::slot_of(scan_ptr_reg);

    // pointer and scan updates
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_cnt_next = scan_cnt_reg;
        rd_pend_next  = rd_pend_reg;
        if (cmd.start)
        begin
            scan_ptr_next = tail_reg;
            scan_cnt_next = '0;
            rd_pend_next  = 1'b0;
        end
        if (cmd.scan_step)
        begin
            rd_pend_next = sts.scan_more;
            if (sts.scan_more)
            begin
                scan_ptr_next = ecrqd_pkg::step_ptr(scan_ptr_reg, mode_reg);
                scan_cnt_next = scan_cnt_reg + ecrqd_pkg::PTR_W'(1);
            end
        end
        if (wr_en)
        begin
            head_next = ecrqd_pkg::step_ptr(head_reg, mode_reg);
        end
        if (cmd.deq && q_not_empty)
        begin
            tail_next = ecrqd_pkg::step_ptr(tail_reg, mode_reg);
        end
    end

    // output register handoff
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            scan_ptr_reg  <= '0;
            scan_cnt_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            scan_ptr_reg  <= scan_ptr_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    // code memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_store_reg[ecrqd_pkg::slot_of(head_reg)] <= code_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= code_store_reg[rd_addr];
        end
    end

    // request payload and result flags
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            code_reg    <= in_data.code_in;
            stored_reg  <= 1'b0;
            fwd_reg     <= 1'b0;
            deq_hit_reg <= 1'b0;
        end
        if (cmd.enq)
        begin
            stored_reg <= !frozen;
            fwd_reg    <= 1'b1;
        end
        if (cmd.deq)
        begin
            deq_hit_reg <= q_not_empty;
        end
        if (cmd.load_out)
        begin
            out_data_reg.code_out  <= deq_hit_reg ? rd_data_reg : '0;
            out_data_reg.stored    <= stored_reg;
            out_data_reg.forwarded <= fwd_reg;
            out_data_reg.not_empty <= q_not_empty;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // scan never looks at more entries than the queue holds
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= ecrqd_pkg::PTR_W'(ecrqd_pkg::QUEUE_DEPTH))
        else $error("scan count past queue depth");

    // pointers stay within the slot range plus the one-shot end mark
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= ecrqd_pkg::PTR_W'(ecrqd_pkg::QUEUE_DEPTH) &&
        tail_reg <= ecrqd_pkg::PTR_W'(ecrqd_pkg::QUEUE_DEPTH))
        else $error("queue pointer out of range");

    // a result is never loaded over one that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result register overwritten");

    // a stored code always moves the head
    a_head_moves: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> head_reg != $past(head_reg))
        else $error("head did not advance on store");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // scoreboard: queue predictor plus the list of results still owed by the block
    class dedup_scoreboard;
        logic [ecrqd_pkg::CODE_W-1:0] codes [ecrqd_pkg::QUEUE_DEPTH];
        logic [ecrqd_pkg::PTR_W-1:0]  head;
        logic [ecrqd_pkg::PTR_W-1:0]  tail;
        logic                         one_shot;
        ecrqd_pkg::rsp_t              pending [$];
        int                           errors;
        int                           requests;
        int                           checked;
        int                           n_stored;
        int                           n_dups;
        int                           n_frozen;
        int                           n_deq_data;
        int                           n_deq_empty;
        int                           n_overruns;
        int                           mode_writes;

        // state after reset
        function new();
            head     = '0;
            tail     = '0;
            one_shot = 1'b0;
        endfunction

        // pointer at or past the end addresses entry 0
        function logic [ecrqd_pkg::SLOT_W-1:0] slot(input logic [ecrqd_pkg::PTR_W-1:0] p);
            return (p < ecrqd_pkg::PTR_W'(ecrqd_pkg::QUEUE_DEPTH)) ?
                   p[ecrqd_pkg::SLOT_W-1:0] : '0;
        endfunction

        // next pointer, wrapping only in circular mode
        function logic [ecrqd_pkg::PTR_W-1:0] advance(input logic [ecrqd_pkg::PTR_W-1:0] p);
            logic [ecrqd_pkg::PTR_W-1:0] n;
            n = ecrqd_pkg::PTR_W'(slot(p)) + ecrqd_pkg::PTR_W'(1);
            if (!one_shot && n >= ecrqd_pkg::PTR_W'(ecrqd_pkg::QUEUE_DEPTH))
            begin
                n = '0;
            end
            return n;
        endfunction

        // duplicate scan from tail toward head, bounded by the depth
        function logic holds(input logic [ecrqd_pkg::CODE_W-1:0] c);
            logic [ecrqd_pkg::PTR_W-1:0] i;
            int                          n;
            i = tail;
            n = 0;
            while (i != head && n < ecrqd_pkg::QUEUE_DEPTH)
            begin
                if (codes[slot(i)] == c)
                begin
                    return 1'b1;
                end
                i = advance(i);
                n++;
            end
            return 1'b0;
        endfunction

        // write at head; one-shot freezes once the head reaches the end
        function logic push_code(input logic [ecrqd_pkg::CODE_W-1:0] c);
            if (one_shot)
            begin
                if (head >= ecrqd_pkg::PTR_W'(ecrqd_pkg::QUEUE_DEPTH))
                begin
                    n_frozen++;
                    return 1'b0;
                end
                codes[head[ecrqd_pkg::SLOT_W-1:0]] = c;
                head = head + ecrqd_pkg::PTR_W'(1);
                n_stored++;
                return 1'b1;
            end
            codes[slot(head)] = c;
            head = advance(head);
            n_stored++;
            if (head == tail)
            begin
                n_overruns++;
            end
            return 1'b1;
        endfunction

        // accepted request: advance the predicted queue and owe one result
        function void note_req(input ecrqd_pkg::req_t r);
            ecrqd_pkg::rsp_t e;
            e = '0;
            requests++;
            case (r.func)
                ecrqd_pkg::FUNC_ENQ:
                begin
                    e.stored    = push_code(r.code_in);
                    e.forwarded = 1'b1;
                end
                ecrqd_pkg::FUNC_ENQ_ONCE:
                begin
                    if (holds(r.code_in))
                    begin
                        n_dups++;
                    end
                    else
                    begin
                        e.stored    = push_code(r.code_in);
                        e.forwarded = 1'b1;
                    end
                end
                ecrqd_pkg::FUNC_DEQ:
                begin
                    if (tail != head)
                    begin
                        e.code_out = codes[slot(tail)];
                        tail       = advance(tail);
                        n_deq_data++;
                    end
                    else
                    begin
                        n_deq_empty++;
                    end
                end
                default:
                begin
                end
            endcase
            e.not_empty = (head != tail);
            pending.push_back(e);
        endfunction

        // one line per mismatch
        task report(input string what);
            errors++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        // compare an accepted result with the oldest owed one
        task check_rsp(input ecrqd_pkg::rsp_t got);
            ecrqd_pkg::rsp_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("result %h with no request waiting", got));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.code_out !== e.code_out)
            begin
                report($sformatf("code_out %h, expected %h", got.code_out, e.code_out));
            end
            if (got.stored !== e.stored)
            begin
                report($sformatf("stored %b, expected %b", got.stored, e.stored));
            end
            if (got.forwarded !== e.forwarded)
            begin
                report($sformatf("forwarded %b, expected %b", got.forwarded, e.forwarded));
            end
            if (got.not_empty !== e.not_empty)
            begin
                report($sformatf("not_empty %b, expected %b", got.not_empty, e.not_empty));
            end
        endtask
    endclass

    // codes that recur often so duplicates are common
    localparam logic [47:0] COMMON_CODES = 48'h00FF01805AA5;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    ecrqd_pkg::req_t in_data   = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    ecrqd_pkg::rsp_t out_data;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic            cfg_data  = 1'b0;
    logic            quiet     = 1'b0;
    int              stall_left = 0;
    dedup_scoreboard sb;

    error_code_ring_queue_dedup_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always #6 clk = ~clk;

    // idle length: mostly short, sometimes long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // code choice: common values, the code at the tail, or anything
    function automatic logic [ecrqd_pkg::CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return COMMON_CODES[$urandom_range(0, 5) * 8 +: 8];
        end
        if (r < 6 && sb.head != sb.tail)
        begin
            return sb.codes[sb.slot(sb.tail)];
        end
        return ecrqd_pkg::CODE_W'($urandom_range(0, 255));
    endfunction

    // result side stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            if (stall_left == 0)
            begin
                out_stall <= 1'b0;
            end
        end
        else if (!quiet && $urandom_range(0, 99) < 25)
        begin
            stall_left = idle_len();
            out_stall <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_rsp(out_data);
        end
    end

    // present one request after a random gap and wait for its acceptance
    task automatic send_req(input logic [ecrqd_pkg::FUNC_W-1:0] f,
                            input logic [ecrqd_pkg::CODE_W-1:0] c);
        int              gap;
        ecrqd_pkg::req_t r;
        r.func    = f;
        r.code_in = c;
        gap = (quiet || $urandom_range(0, 99) < 50) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
        sb.note_req(r);
    endtask

    // hold off requests until every owed result has come back
    task automatic quiesce();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
    endtask

    // dequeue until the queue is predicted empty
    task automatic drain();
        while (sb.head != sb.tail)
        begin
            send_req(ecrqd_pkg::FUNC_DEQ, ecrqd_pkg::CODE_W'($urandom_range(0, 255)));
        end
    endtask

    // mode register write
    task automatic set_mode(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.one_shot = v;
        sb.mode_writes++;
    endtask

    // random bursts: fills, drains and mixed traffic
    task automatic run_phase(input int count);
        int kind;
        int len;
        int i;
        logic [ecrqd_pkg::FUNC_W-1:0] f;
        while (count > 0)
        begin
            kind  = $urandom_range(0, 9);
            quiet = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 39) == 0)
            begin
                quiesce();
            end
            len = (kind < 4) ? $urandom_range(1, 20) :
                  (kind < 7) ? $urandom_range(1, 18) : $urandom_range(1, 12);
            for (i = 0; i < len && count > 0; i++)
            begin
                if (kind < 4)
                begin
                    f = $urandom_range(0, 1) ? ecrqd_pkg::FUNC_ENQ_ONCE : ecrqd_pkg::FUNC_ENQ;
                end
                else if (kind < 7)
                begin
                    f = ecrqd_pkg::FUNC_DEQ;
                end
                else
                begin
                    case ($urandom_range(0, 19))
                        0:       f = ecrqd_pkg::FUNC_NOP;
                        1, 2, 3,
                        4, 5, 6: f = ecrqd_pkg::FUNC_DEQ;
                        7, 8, 9,
                        10, 11:  f = ecrqd_pkg::FUNC_ENQ;
                        default: f = ecrqd_pkg::FUNC_ENQ_ONCE;
                    endcase
                end
                send_req(f, pick_code());
                count--;
            end
        end
        quiet = 1'b0;
    endtask

    // main sequence
    initial
    begin
        int p;
        sb = new;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, circular: empty dequeue, no-op, duplicates, field extremes
        set_mode(1'b0);
        send_req(ecrqd_pkg::FUNC_DEQ, 8'hFF);
        send_req(ecrqd_pkg::FUNC_NOP, 8'hFF);
        send_req(ecrqd_pkg::FUNC_NOP, 8'h00);
        send_req(ecrqd_pkg::FUNC_ENQ, 8'h00);
        send_req(ecrqd_pkg::FUNC_ENQ, 8'hFF);
        send_req(ecrqd_pkg::FUNC_ENQ_ONCE, 8'hFF);
        send_req(ecrqd_pkg::FUNC_ENQ_ONCE, 8'h00);
        send_req(ecrqd_pkg::FUNC_ENQ_ONCE, 8'hA5);
        send_req(ecrqd_pkg::FUNC_ENQ_ONCE, 8'h5A);
        repeat (5) send_req(ecrqd_pkg::FUNC_DEQ, 8'h00);
        send_req(ecrqd_pkg::FUNC_ENQ_ONCE, 8'h00);
        send_req(ecrqd_pkg::FUNC_DEQ, 8'hFF);

        // directed, one-shot
        quiesce();
        set_mode(1'b1);
        send_req(ecrqd_pkg::FUNC_DEQ, 8'h00);
        send_req(ecrqd_pkg::FUNC_ENQ_ONCE, 8'h3C);
        send_req(ecrqd_pkg::FUNC_ENQ_ONCE, 8'h3C);
        send_req(ecrqd_pkg::FUNC_ENQ, 8'h00);
        repeat (3) send_req(ecrqd_pkg::FUNC_DEQ, 8'hFF);

        // random phases, alternating mode with the queue emptied in between
        for (p = 0; p < 12; p++)
        begin
            drain();
            quiesce();
            set_mode(p % 2 == 0);
            run_phase((p % 2 == 0) ? 40 : 110);
        end

        quiesce();
        repeat (30) @(posedge clk);

        $display("%0d requests, %0d results checked in %0d mode settings",
                 sb.requests, sb.checked, sb.mode_writes);
        $display("%0d stored, %0d duplicates, %0d frozen, %0d/%0d dequeues, %0d overruns",
                 sb.n_stored, sb.n_dups, sb.n_frozen, sb.n_deq_data, sb.n_deq_empty,
                 sb.n_overruns);
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #(6_000_000);
        $display("timeout with %0d results still owed", sb.pending.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ecrqd_pkg.sv
rtl/ecrqd_ctrl.sv
rtl/ecrqd_dp.sv
rtl/error_code_ring_queue_dedup_unit.sv
test/testbench.sv
